@@ rtl/assert_macros.svh @@
// assertion macros for the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SSI_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssi assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define SSI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssi assertion failed");

`endif

@@ rtl/ssi_pkg.sv @@
// shared types and constants of the sorted set insert core
package ssi_pkg;

    localparam int ELEM_W   = 31;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] STAT_LISTED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_DUP    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd2;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic cmp;   // compare stored value with the broadcast value
        logic ins;   // open the gap and insert the broadcast value
        logic rot;   // rotate the ring one place toward cell 0
    } cell_ctl_t;

endpackage

@@ rtl/ssi_cell.sv @@
// one storage cell of the sorted chain
module ssi_cell import ssi_pkg::*;
#(
    parameter int W = 31
)
(
    input  logic         clk,
    input  cell_ctl_t    ctl,
    input  logic         occupied,
    input  logic [W-1:0] v,
    input  logic         left_lt,
    input  logic [W-1:0] left_val,
    input  logic [W-1:0] right_val,
    output logic [W-1:0] val,
    output logic         lt,
    output logic         eq
);

    logic [W-1:0] val_reg;
    logic [W-1:0] val_next;
    logic         lt_reg;
    logic         lt_next;
    logic         eq_reg;
    logic         eq_next;

    always_comb
    begin
        val_next = val_reg;
        lt_next  = lt_reg;
        eq_next  = eq_reg;
        if (ctl.cmp)
        begin
            lt_next = occupied && (val_reg < v);
            eq_next = occupied && (val_reg == v);
        end
        if (ctl.ins)
        begin
            // smaller entries stay, the first larger one takes v, the rest move up
            if (lt_reg)
                val_next = val_reg;
            else if (left_lt)
                val_next = v;
            else
                val_next = left_val;
        end
        else if (ctl.rot)
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        lt_reg  <= lt_next;
        eq_reg  <= eq_next;
    end

    assign val = val_reg;
    assign lt  = lt_reg;
    assign eq  = eq_reg;

endmodule

@@ rtl/sorted_set_insert_dedup_core.sv @@
// top level of the sorted set insert core with duplicate rejection
//
// channel  | signals                                   | handshake
// ---------+-------------------------------------------+------------------------------
// command  | start, busy, new_value                    | taken when start && !busy
// result   | result_valid, status, element, position,  | one-cycle strobe, no stall
//          | last_of_run                               |
//
// a duplicate or full transaction keeps busy high through CMP, TREE and DECIDE
// after the accept edge, so the next one is taken only after the return to IDLE
// an insert keeps busy high through CMP, TREE, DECIDE and LIST: the ring of cells
// turns once, listing the first entry_count entries from cell 0, one per cycle
// results appear in the cycle after the cell data they are taken from
// reset (rst_n, async) clears the count and the control; cell contents stay undefined
// the receiver cannot stall, so results are never held back
module sorted_set_insert_dedup_core import ssi_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 31
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [ELEM_W-1:0]   new_value,
    output logic                result_valid,
    output logic [STATUS_W-1:0] status,
    output logic [ELEM_W-1:0]   element,
    output logic [POS_W-1:0]    position,
    output logic                last_of_run
);

    // stored width: input bits above VALUE_BITS are dropped
    localparam int SW   = (VALUE_BITS < ELEM_W) ? VALUE_BITS : ELEM_W;
    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int NG   = (CAPACITY + 7) / 8;
    localparam int PADW = NG * 8;

    // sequencer codes
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CMP    = 3'd1;
    localparam logic [2:0] S_TREE   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_LIST   = 3'd4;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [SW-1:0]       v_reg;
    logic [CW-1:0]       cnt_reg;
    logic [CW-1:0]       cnt_next;
    logic [IW-1:0]       pos_reg;
    logic [IW-1:0]       pos_next;
    logic [NG-1:0]       grp_reg;
    logic [NG-1:0]       grp_next;

    logic                rv_reg;
    logic                rv_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [ELEM_W-1:0]   elem_reg;
    logic [ELEM_W-1:0]   elem_next;
    logic [POS_W-1:0]    posout_reg;
    logic [POS_W-1:0]    posout_next;
    logic                last_reg;
    logic                last_next;

    cell_ctl_t           ctl;
    logic [CAPACITY-1:0] occ_vec;
    logic [CAPACITY-1:0] lt_vec;
    logic [CAPACITY-1:0] eq_vec;
    logic [PADW-1:0]     eq_pad;
    logic [SW-1:0]       val_arr [CAPACITY];

    logic                accept;
    logic                dup;
    logic                full;
    logic [CW-1:0]       pos_ext;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    // chain of cells: each sees its lower neighbor for inserts and its
    // upper neighbor for rotation, the top cell wraps to cell 0
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic          l_lt;
            logic [SW-1:0] l_val;
            logic [SW-1:0] r_val;

            assign occ_vec[gi] = (CW'(gi) < cnt_reg);

            if (gi == 0)
            begin : g_first
                // cell 0 behaves as if a smaller entry sat to its left
                assign l_lt  = 1'b1;
                assign l_val = v_reg;
            end
            else
            begin : g_rest
                assign l_lt  = lt_vec[gi-1];
                assign l_val = val_arr[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_top
                assign r_val = val_arr[0];
            end
            else
            begin : g_mid
                assign r_val = val_arr[gi+1];
            end

            ssi_cell #(
                .W(SW)
            ) u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .occupied  (occ_vec[gi]),
                .v         (v_reg),
                .left_lt   (l_lt),
                .left_val  (l_val),
                .right_val (r_val),
                .val       (val_arr[gi]),
                .lt        (lt_vec[gi]),
                .eq        (eq_vec[gi])
            );
        end
    endgenerate

    // duplicate search: groups of eight match bits are or-ed into a register
    assign eq_pad = PADW'(eq_vec);

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_next[g] = |eq_pad[g*8 +: 8];
        end
    end

    assign dup     = |grp_reg;
    assign full    = (cnt_reg == CW'(CAPACITY));
    assign pos_ext = CW'(pos_reg);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        ctl         = '0;
        rv_next     = 1'b0;
        status_next = STAT_LISTED;
        elem_next   = '0;
        posout_next = '0;
        last_next   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                ctl.cmp    = 1'b1;
                state_next = S_TREE;
            end
            S_TREE:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (dup)
                begin
                    rv_next     = 1'b1;
                    status_next = STAT_DUP;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (full)
                begin
                    rv_next     = 1'b1;
                    status_next = STAT_FULL;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ctl.ins    = 1'b1;
                    cnt_next   = cnt_reg + CW'(1);
                    pos_next   = '0;
                    state_next = S_LIST;
                end
            end
            S_LIST:
            begin
                // cell 0 holds entry pos_reg; keep turning until the ring is home
                ctl.rot     = 1'b1;
                rv_next     = (pos_ext < cnt_reg);
                status_next = STAT_LISTED;
                elem_next   = ELEM_W'(val_arr[0]);
                posout_next = POS_W'(pos_reg);
                last_next   = (CW'(pos_ext + CW'(1)) == cnt_reg);
                pos_next    = pos_reg + IW'(1);
                if (pos_reg == IW'(CAPACITY - 1))
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            v_reg <= new_value[SW-1:0];
        pos_reg    <= pos_next;
        grp_reg    <= grp_next;
        status_reg <= status_next;
        elem_reg   <= elem_next;
        posout_reg <= posout_next;
        last_reg   <= last_next;
    end

    assign result_valid = rv_reg;
    assign status       = status_reg;
    assign element      = elem_reg;
    assign position     = posout_reg;
    assign last_of_run  = last_reg;

endmodule

@@ rtl/ssi_checker.sv @@
// port-level checker for the sorted set insert core, with its bind
`include "assert_macros.svh"

module ssi_checker import ssi_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                result_valid,
    input logic [STATUS_W-1:0] status,
    input logic [ELEM_W-1:0]   element,
    input logic [POS_W-1:0]    position,
    input logic                last_of_run
);

    // a taken transaction keeps the core busy in the next cycle
    `SSI_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

    // rejections are single results with cleared payload
    `SSI_ASSERT_SAME(a_reject_single, result_valid && (status == STAT_DUP || status == STAT_FULL),
        last_of_run && element == '0 && position == '0)

    // a listing continues in the next cycle with the next position
    `SSI_ASSERT_NEXT(a_list_next, result_valid && status == STAT_LISTED && !last_of_run,
        result_valid && status == STAT_LISTED && position == POS_W'($past(position) + 1'b1))

    // listed elements rise strictly
    `SSI_ASSERT_NEXT(a_list_sorted, result_valid && status == STAT_LISTED && !last_of_run,
        element > $past(element))

endmodule

bind sorted_set_insert_dedup_core ssi_checker u_ssi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .status       (status),
    .element      (element),
    .position     (position),
    .last_of_run  (last_of_run)
);

@@ tb/tb_sorted_set_insert_dedup_core.sv @@
// self-checking testbench for the sorted set insert core with duplicate rejection
`timescale 1ns / 1ps

module tb_sorted_set_insert_dedup_core;
    import ssi_pkg::*;

    localparam int CAPACITY    = 64;
    localparam int VALUE_BITS  = 31;
    localparam int CYCLE_LIMIT = 200000;
    // an insert keeps the ring turning for the rest of a revolution after the last listing
    localparam int DRAIN_CYCLES = CAPACITY + 16;

    localparam logic [ELEM_W-1:0] VALUE_MAX = {ELEM_W{1'b1}};

    // one listing, duplicate or full result as the block should produce it
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ELEM_W-1:0]   element;
        logic [POS_W-1:0]    position;
        logic                last_flag;
    } listing_t;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                start     = 1'b0;
    logic [ELEM_W-1:0]   new_value = '0;
    logic                busy;
    logic                result_valid;
    logic [STATUS_W-1:0] status;
    logic [ELEM_W-1:0]   element;
    logic [POS_W-1:0]    position;
    logic                last_of_run;

    // shadow copy of the sorted set, only entries below set_count are valid
    logic [ELEM_W-1:0] set_shadow [CAPACITY];
    int                set_count = 0;

    listing_t expected_listing_q [$];

    int error_count    = 0;
    int cycle_count    = 0;
    int sent_count     = 0;
    int insert_count   = 0;
    int dup_count      = 0;
    int full_count     = 0;
    int checked_count  = 0;
    bit idle_enable    = 1'b1;

    sorted_set_insert_dedup_core #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .new_value    (new_value),
        .result_valid (result_valid),
        .status       (status),
        .element      (element),
        .position     (position),
        .last_of_run  (last_of_run)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_listing_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // works out what one insert attempt gives and updates the shadow set
    task automatic predict_insert(input logic [ELEM_W-1:0] value);
        int       slot;
        int       j;
        listing_t entry;
        slot = 0;
        while (slot < set_count && set_shadow[slot] < value)
            slot++;
        if (slot < set_count && set_shadow[slot] == value)
        begin
            entry = '{status: STAT_DUP, element: '0, position: '0, last_flag: 1'b1};
            expected_listing_q.push_back(entry);
            dup_count++;
        end
        else if (set_count >= CAPACITY)
        begin
            entry = '{status: STAT_FULL, element: '0, position: '0, last_flag: 1'b1};
            expected_listing_q.push_back(entry);
            full_count++;
        end
        else
        begin
            for (j = set_count; j > slot; j--)
                set_shadow[j] = set_shadow[j-1];
            set_shadow[slot] = value;
            set_count++;
            for (j = 0; j < set_count; j++)
            begin
                entry.status    = STAT_LISTED;
                entry.element   = set_shadow[j];
                entry.position  = POS_W'(j);
                entry.last_flag = (j + 1 == set_count);
                expected_listing_q.push_back(entry);
            end
            insert_count++;
        end
    endtask

    // offers one value, returns at the edge where the transaction is taken
    task automatic send_value(input logic [ELEM_W-1:0] value);
        int gap;
        // switch between idling and back-to-back stretches now and then
        if (sent_count % 32 == 0)
            idle_enable = $urandom_range(0, 3) != 0;
        gap = idle_enable ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        new_value <= value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_insert(value);
        sent_count++;
    endtask

    // sender holds off until every outstanding result has been seen
    task automatic wait_all_results();
        start <= 1'b0;
        @(posedge clk);
        while (expected_listing_q.size() != 0)
            @(posedge clk);
    endtask

    // picks a value: an existing entry, a small value, or anything
    function automatic logic [ELEM_W-1:0] pick_value(input int dup_weight);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < dup_weight && set_count > 0)
            return set_shadow[$urandom_range(0, set_count - 1)];
        else if (sel < dup_weight + 2)
            return ELEM_W'($urandom_range(0, 255));
        else
            return ELEM_W'($urandom);
    endfunction

    // every result strobe is matched against the oldest expectation
    always @(posedge clk)
    begin
        listing_t want;
        if (rst_n && result_valid)
        begin
            if (expected_listing_q.size() == 0)
            begin
                $error("result with no transaction pending: status %0d element %0h position %0d",
                       status, element, position);
                error_count++;
            end
            else
            begin
                want = expected_listing_q.pop_front();
                checked_count++;
                if (status !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, status);
                    error_count++;
                end
                if (element !== want.element)
                begin
                    $error("element mismatch: expected %0h, actual %0h", want.element, element);
                    error_count++;
                end
                if (position !== want.position)
                begin
                    $error("position mismatch: expected %0d, actual %0d",
                           want.position, position);
                    error_count++;
                end
                if (last_of_run !== want.last_flag)
                begin
                    $error("last_of_run mismatch: expected %0d, actual %0d",
                           want.last_flag, last_of_run);
                    error_count++;
                end
            end
        end
    end

    // inserts at the front, back and middle, extremes and their duplicates
    task automatic test_directed_edges();
        send_value(ELEM_W'(1000));
        send_value(ELEM_W'(5));
        send_value(ELEM_W'(0));
        send_value(VALUE_MAX);
        send_value(ELEM_W'(500));
        send_value(ELEM_W'(0));
        send_value(VALUE_MAX);
        send_value(ELEM_W'(500));
        send_value(ELEM_W'(31'h2AAA_AAAA));
        send_value(ELEM_W'(31'h5555_5555));
        send_value(VALUE_MAX - ELEM_W'(1));
        send_value(ELEM_W'(1));
        send_value(ELEM_W'(1));
    endtask

    // random inserts with some duplicates until the set is nearly full
    task automatic test_random_fill();
        while (set_count < CAPACITY - 2)
            send_value(pick_value(2));
    endtask

    // last free places, then rejection on a full store
    task automatic test_full_store();
        send_value(ELEM_W'(31'h4000_0000));
        send_value(ELEM_W'(31'h3FFF_FFFF));
        // new values are dropped now, stored ones still count as duplicates
        send_value(ELEM_W'(31'h0123_4567));
        send_value(ELEM_W'(0));
        send_value(VALUE_MAX);
        send_value(ELEM_W'(31'h4000_0000));
        send_value(set_shadow[CAPACITY/2]);
        send_value(ELEM_W'(31'h7FFF_FFFD));
    endtask

    // random traffic against the full store
    task automatic test_random_full(input int item_total);
        repeat (item_total)
            send_value(pick_value(5));
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        wait_all_results();
        test_random_fill();
        wait_all_results();
        test_full_store();
        wait_all_results();
        test_random_full(200);
        wait_all_results();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_listing_q.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_listing_q.size());
            error_count++;
        end

        $display("sent %0d transactions: %0d inserts, %0d duplicates, %0d full drops",
                 sent_count, insert_count, dup_count, full_count);
        $display("checked %0d results, set grew to %0d of %0d entries",
                 checked_count, set_count, CAPACITY);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
